// ----- rtl/core/psld_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psld_pkg
// Shared types, register indexes and saturation helpers for the speed-loop
// PID block.
// ----------------------------------------------------------------------------
package psld_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int GAIN_W    = 31;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS = 3'd6;

    // multiplier operand selection
    typedef enum logic [1:0] {
        MUL_MEAS = 2'd0,
        MUL_P    = 2'd1,
        MUL_I    = 2'd2,
        MUL_D    = 2'd3
    } psld_mul_sel_t;

    typedef struct packed {
        logic          load_in;
        logic          mul_en;
        psld_mul_sel_t mul_sel;
        logic          ld_err;
        logic          ld_act;
        logic          ld_p;
        logic          ld_i;
        logic          ld_drive;
        logic          ld_out;
    } psld_cmd_t;

    typedef struct packed {
        logic out_full;
    } psld_status_t;

    localparam logic signed [51:0] S32_MAX = 52'sd2147483647;
    localparam logic signed [51:0] S32_MIN = -52'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
        logic signed [31:0] r;
        if (x > S32_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < S32_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [51:0] clamp_sym(input logic signed [51:0] x,
                                                     input logic [GAIN_W-1:0] lim);
        logic signed [51:0] l;
        logic signed [51:0] r;
        l = $signed({21'd0, lim});
        if (x > l) begin
            r = l;
        end else if (x < -l) begin
            r = -l;
        end else begin
            r = x;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/psld_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psld_ctrl
// Sequencer: walks one control tick through the shared multiplier and the
// accumulate/clamp steps of the datapath.
// ----------------------------------------------------------------------------
module psld_ctrl
    import psld_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         m_ready,
    input  psld_status_t status,
    output psld_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MEAS = 8'b0000_0010,
        ST_ERR  = 8'b0000_0100,
        ST_MULP = 8'b0000_1000,
        ST_MULI = 8'b0001_0000,
        ST_MULD = 8'b0010_0000,
        ST_SUM  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_MEAS;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MEAS;
                end
            end
            ST_MEAS: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MEAS;
                state_next  = ST_ERR;
            end
            ST_ERR: begin
                cmd.ld_err = 1'b1;
                state_next = ST_MULP;
            end
            ST_MULP: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_P;
                cmd.ld_act  = 1'b1;
                state_next  = ST_MULI;
            end
            ST_MULI: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_I;
                cmd.ld_p    = 1'b1;
                state_next  = ST_MULD;
            end
            ST_MULD: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_D;
                cmd.ld_i    = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                cmd.ld_drive = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (!status.out_full || m_ready) begin
                    cmd.ld_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/psld_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psld_datapath
// Config registers, loop state, one shared 34x32 multiplier, clamps and the
// output register.
// ----------------------------------------------------------------------------
module psld_datapath
    import psld_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  psld_cmd_t            cmd,
    output psld_status_t         status,
    input  logic signed [31:0]   s_target_speed,
    input  logic signed [31:0]   s_wheel_rate,
    input  logic signed [31:0]   s_balance_drive,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 m_ready,
    output logic signed [31:0]   m_total_drive,
    output logic signed [31:0]   m_speed_drive
);

    logic [GAIN_W-1:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [GAIN_W-1:0] integ_limit_reg, drive_limit_reg, dead_band_reg, radius_reg;

    logic signed [31:0] target_reg, rate_reg, balance_reg;
    logic signed [65:0] prod_reg;
    logic signed [31:0] err_reg;
    logic               act_reg;
    logic signed [49:0] p_reg;
    logic signed [31:0] i_reg;
    logic signed [31:0] drive_reg;
    logic signed [31:0] integ_reg, last_err_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_total_reg, out_speed_reg;

    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [65:0] mul_out;
    logic signed [33:0] err_diff;
    logic signed [49:0] prod_sh;
    logic signed [31:0] meas;
    logic signed [31:0] err_next;
    logic signed [32:0] err_ext;
    logic        [32:0] err_mag;
    logic signed [51:0] i_clamped;
    logic signed [51:0] drive_clamped;
    logic signed [31:0] total_next;

    // configuration writes; only the low 31 bits are kept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            integ_limit_reg <= '0;
            drive_limit_reg <= '0;
            dead_band_reg   <= '0;
            radius_reg      <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PROP_GAIN:    prop_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:   integ_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:   deriv_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_INTEG_LIMIT:  integ_limit_reg <= cfg_data[GAIN_W-1:0];
                REG_DRIVE_LIMIT:  drive_limit_reg <= cfg_data[GAIN_W-1:0];
                REG_DEAD_BAND:    dead_band_reg   <= cfg_data[GAIN_W-1:0];
                REG_WHEEL_RADIUS: radius_reg      <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign err_diff = {{2{err_reg[31]}}, err_reg} - {{2{last_err_reg[31]}}, last_err_reg};

    always_comb begin
        mul_a = {{2{rate_reg[31]}}, rate_reg};
        mul_b = $signed({1'b0, radius_reg});
        case (cmd.mul_sel)
            MUL_MEAS: begin
                mul_a = {{2{rate_reg[31]}}, rate_reg};
                mul_b = $signed({1'b0, radius_reg});
            end
            MUL_P: begin
                mul_a = {{2{err_reg[31]}}, err_reg};
                mul_b = $signed({1'b0, prop_gain_reg});
            end
            MUL_I: begin
                mul_a = {{2{err_reg[31]}}, err_reg};
                mul_b = $signed({1'b0, integ_gain_reg});
            end
            MUL_D: begin
                mul_a = err_diff;
                mul_b = $signed({1'b0, deriv_gain_reg});
            end
            default: ;
        endcase
    end

    assign mul_out = mul_a * mul_b;

    // arithmetic shift by 16 rounds toward minus infinity
    assign prod_sh  = prod_reg[65:16];
    assign meas     = sat32({{2{prod_sh[49]}}, prod_sh});
    assign err_next = sat32({{20{target_reg[31]}}, target_reg} - {{20{meas[31]}}, meas});
    assign err_ext  = {err_reg[31], err_reg};
    assign err_mag  = err_reg[31] ? unsigned'(-err_ext) : unsigned'(err_ext);

    assign i_clamped = clamp_sym({{20{integ_reg[31]}}, integ_reg} + {{2{prod_sh[49]}}, prod_sh},
                                 integ_limit_reg);
    assign drive_clamped = clamp_sym({{2{p_reg[49]}}, p_reg} + {{20{i_reg[31]}}, i_reg}
                                     + {{2{prod_sh[49]}}, prod_sh}, drive_limit_reg);
    assign total_next = sat32({{20{balance_reg[31]}}, balance_reg}
                              + {{20{drive_reg[31]}}, drive_reg});

    // payload path
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            target_reg  <= s_target_speed;
            rate_reg    <= s_wheel_rate;
            balance_reg <= s_balance_drive;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_out;
        end
        if (cmd.ld_err) begin
            err_reg <= err_next;
        end
        if (cmd.ld_act) begin
            act_reg <= err_mag > {2'b00, dead_band_reg};
        end
        if (cmd.ld_p) begin
            p_reg <= prod_sh;
        end
        if (cmd.ld_i) begin
            i_reg <= i_clamped[31:0];
        end
        if (cmd.ld_drive) begin
            drive_reg <= act_reg ? drive_clamped[31:0] : 32'sd0;
        end
        if (cmd.ld_out) begin
            out_total_reg <= total_next;
            out_speed_reg <= drive_reg;
        end
    end

    // loop state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg     <= '0;
            last_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.ld_drive) begin
                last_err_reg <= err_reg;
                if (act_reg) begin
                    integ_reg <= i_reg;
                end
            end
            if (cmd.ld_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_full = out_valid_reg;
    assign m_total_drive   = out_total_reg;
    assign m_speed_drive   = out_speed_reg;

endmodule

// ----- rtl/core/pid_speed_loop_deadzone_unit.sv -----
`timescale 1ns / 1ps
// One control tick runs from input beat to result through the sequencer,
// which shares a single 34x32 multiplier over the wheel-speed, P, I and D
// products; the next beat is taken as soon as the result is in the output
// register, even while that result still waits for m_ready. Config writes
// are always ready and must only be issued while no tick is in flight.
// ----------------------------------------------------------------------------
// pid_speed_loop_deadzone_unit
// Speed-loop PID with dead zone and integral clamp, summed with a balance
// drive term; Q16.16 throughout.
// ----------------------------------------------------------------------------
module pid_speed_loop_deadzone_unit
    import psld_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_target_speed,
    input  logic signed [31:0]   s_wheel_rate,
    input  logic signed [31:0]   s_balance_drive,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_total_drive,
    output logic signed [31:0]   m_speed_drive,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    psld_cmd_t    cmd;
    psld_status_t status;

    psld_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    psld_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_target_speed  (s_target_speed),
        .s_wheel_rate    (s_wheel_rate),
        .s_balance_drive (s_balance_drive),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_ready         (m_ready),
        .m_total_drive   (m_total_drive),
        .m_speed_drive   (m_speed_drive)
    );

    assign m_valid   = status.out_full;
    assign cfg_ready = 1'b1;

    // an accepted beat starts the wheel-speed multiply next cycle
    a_start_meas: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (cmd.mul_en && cmd.mul_sel == MUL_MEAS && !s_ready))
        else $error("tick did not start after input beat");

    // result register is only loaded when free or being drained
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_out |-> (!m_valid || m_ready))
        else $error("pending result overwritten");

    // a new result appears only from the sequencer's load
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.ld_out))
        else $error("result valid without load");

endmodule
